// ----- rtl/ltds_pkg.sv -----
// ----------------------------------------------------------------------------
// Light threshold dwell switch package
// Shared constants, codes and types of the light threshold dwell switch.
// ----------------------------------------------------------------------------
package ltds_pkg;

  localparam int WINDOW      = 20;
  localparam int SAMPLE_BITS = 16;

  localparam int LIGHT_BITS     = 16;
  localparam int HOLD_BITS      = 8;
  localparam int STAMP_BITS     = 32;
  localparam int EVENT_BITS     = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int FILL_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CMP_BITS  = (SAMPLE_BITS > LIGHT_BITS) ? SAMPLE_BITS : LIGHT_BITS;

  // The mean is the window sum times a rounded-up reciprocal of WINDOW; the shift
  // is wide enough that the quotient is exact over the whole range of the sum.
  localparam int DIV_SHIFT  = SUM_BITS + $clog2(WINDOW);
  localparam int RECIP_BITS = SUM_BITS + 1;
  localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] AVG_RECIP =
    RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [CFG_INDEX_BITS-1:0] REG_LIGHT_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ON_HOLD_TICKS   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFF_HOLD_TICKS  = 2'd2;

  localparam logic [LIGHT_BITS-1:0] LIGHT_THRESHOLD_RESET = 16'd2000;
  localparam logic [HOLD_BITS-1:0]  ON_HOLD_TICKS_RESET   = 8'd50;
  localparam logic [HOLD_BITS-1:0]  OFF_HOLD_TICKS_RESET  = 8'd100;

  typedef enum logic [3:0] {
    ST_OFF      = 4'b0001,
    ST_ON_WAIT  = 4'b0010,
    ST_ON       = 4'b0100,
    ST_OFF_WAIT = 4'b1000
  } state_t;

  typedef enum logic [EVENT_BITS-1:0] {
    EV_NONE = 2'd0,
    EV_ON   = 2'd1,
    EV_OFF  = 2'd2
  } event_t;

  typedef struct packed {
    logic [LIGHT_BITS-1:0] light_threshold;
    logic [HOLD_BITS-1:0]  on_hold_ticks;
    logic [HOLD_BITS-1:0]  off_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic   output_on;
    event_t switch_event;
  } fsm_status_t;

  typedef struct packed {
    logic                  output_on;
    logic [EVENT_BITS-1:0] switch_event;
    logic [STAMP_BITS-1:0] tick_stamp;
    logic [LIGHT_BITS-1:0] window_average;
    logic                  average_valid;
  } result_t;

endpackage

// ----- rtl/ltds_in_if.sv -----
// ----------------------------------------------------------------------------
// Light sample channel
// Valid/ready channel that carries one light sample word per tick.
// ----------------------------------------------------------------------------
interface ltds_in_if;
  import ltds_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [LIGHT_BITS-1:0] light_sample;

  modport source (output valid, output light_sample, input ready);
  modport sink (input valid, input light_sample, output ready);
endinterface

// ----- rtl/ltds_out_if.sv -----
// ----------------------------------------------------------------------------
// Switch result channel
// Valid/ready channel that carries one result word per tick.
// ----------------------------------------------------------------------------
interface ltds_out_if;
  import ltds_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  output_on;
  logic [EVENT_BITS-1:0] switch_event;
  logic [STAMP_BITS-1:0] tick_stamp;
  logic [LIGHT_BITS-1:0] window_average;
  logic                  average_valid;

  modport source (output valid, output output_on, output switch_event, output tick_stamp,
                  output window_average, output average_valid, input ready);
  modport sink (input valid, input output_on, input switch_event, input tick_stamp,
                input window_average, input average_valid, output ready);
endinterface

// ----- rtl/ltds_cell.sv -----
// ----------------------------------------------------------------------------
// Window cell
// One sample of the moving window; shifts its sample on to the next cell.
// ----------------------------------------------------------------------------
module ltds_cell (
  input  logic                             clk,
  input  logic                             shift,
  input  logic [ltds_pkg::SAMPLE_BITS-1:0] d,
  output logic [ltds_pkg::SAMPLE_BITS-1:0] q
);
  import ltds_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end
endmodule

// ----- rtl/ltds_fsm.sv -----
// ----------------------------------------------------------------------------
// Switch state machine
// Four-state on/off machine with minimum dwell after each switch.
// ----------------------------------------------------------------------------
module ltds_fsm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [ltds_pkg::SAMPLE_BITS-1:0] avg,
  input  ltds_pkg::cfg_t                   cfg,
  output ltds_pkg::fsm_status_t            status
);
  import ltds_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [HOLD_BITS-1:0] hold_count;
  logic [HOLD_BITS-1:0] hold_count_next;
  logic [HOLD_BITS-1:0] hold_inc;
  event_t               evt;
  logic [CMP_BITS-1:0]  avg_c;
  logic [CMP_BITS-1:0]  thr_c;
  logic                 above;
  logic                 below;

  assign hold_inc = hold_count + 1'b1;
  assign avg_c    = CMP_BITS'(avg);
  assign thr_c    = CMP_BITS'(cfg.light_threshold);
  assign above    = avg_c > thr_c;
  assign below    = avg_c < thr_c;

  always_comb begin
    state_next      = state;
    hold_count_next = hold_count;
    evt             = EV_NONE;
    if (step) begin
      unique case (state)
        ST_OFF: begin
          if (below) begin
            evt        = EV_ON;
            state_next = ST_ON_WAIT;
          end
        end
        ST_ON_WAIT: begin
          hold_count_next = hold_inc;
          if (hold_inc == cfg.on_hold_ticks) begin
            hold_count_next = '0;
            if (above) begin
              evt        = EV_OFF;
              state_next = ST_OFF_WAIT;
            end else begin
              state_next = ST_ON;
            end
          end
        end
        ST_ON: begin
          if (above) begin
            evt        = EV_OFF;
            state_next = ST_OFF_WAIT;
          end
        end
        ST_OFF_WAIT: begin
          hold_count_next = hold_inc;
          if (hold_inc == cfg.off_hold_ticks) begin
            hold_count_next = '0;
            if (below) begin
              evt        = EV_ON;
              state_next = ST_ON_WAIT;
            end else begin
              state_next = ST_OFF;
            end
          end
        end
        default: begin
          state_next = ST_OFF;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_OFF;
      hold_count <= '0;
    end else begin
      state      <= state_next;
      hold_count <= hold_count_next;
    end
  end

  assign status.output_on    = (state_next == ST_ON_WAIT) || (state_next == ST_ON);
  assign status.switch_event = evt;
endmodule

// ----- rtl/light_threshold_dwell_switch_unit.sv -----
// ----------------------------------------------------------------------------
// Light threshold dwell switch
// Moving-average light switch with minimum dwell after each switch.
// ----------------------------------------------------------------------------
// Each light sample word on the samples channel is one periodic tick. The
// sample enters a shift chain of WINDOW cells and a running window sum. Once
// WINDOW samples have arrived, the truncated mean is compared with the light
// threshold and steps the on/off machine. Every accepted sample gives exactly
// one result word on the results channel: output state, switch event, tick
// stamp, window average and a flag that the window is full.
// The whole tick is worked out in the cycle of acceptance, and the result
// word is registered into the output buffer. A new sample is taken in every
// cycle while the buffer has room. The path from the running sum through the
// reciprocal multiply that divides by WINDOW and the threshold compare sets
// the clock period. A two-word output buffer holds results while the receiver
// stalls; samples are taken until both words are full. Reset clears the tick
// counter, window fill, running sum, machine state and output buffer, and
// loads the default configuration. Configuration words are written through
// cfg_we, cfg_index and cfg_data while the block is idle; the user is bound
// to that, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module light_threshold_dwell_switch_unit (
  input  logic                                clk,
  input  logic                                rst,
  ltds_in_if.sink                             samples,
  ltds_out_if.source                          results,
  input  logic                                cfg_we,
  input  logic [ltds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ltds_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ltds_pkg::*;

  cfg_t                   cfg;
  logic                   accept;
  logic                   full;
  logic                   wrapped;
  logic [FILL_BITS-1:0]   fill_count;
  logic [SUM_BITS-1:0]    window_sum;
  logic [SUM_BITS-1:0]    window_sum_next;
  logic [STAMP_BITS-1:0]  tick_count;
  logic [STAMP_BITS-1:0]  tick_count_next;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] dropped;
  logic [PROD_BITS-1:0]   avg_prod;
  logic [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] taps [WINDOW];
  fsm_status_t            status;
  result_t                word_new;
  result_t                word0;
  result_t                word1;
  logic                   valid0;
  logic                   valid1;
  logic                   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_threshold <= LIGHT_THRESHOLD_RESET;
      cfg.on_hold_ticks   <= ON_HOLD_TICKS_RESET;
      cfg.off_hold_ticks  <= OFF_HOLD_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_THRESHOLD: cfg.light_threshold <= LIGHT_BITS'(cfg_data);
        REG_ON_HOLD_TICKS:   cfg.on_hold_ticks   <= HOLD_BITS'(cfg_data);
        REG_OFF_HOLD_TICKS:  cfg.off_hold_ticks  <= HOLD_BITS'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  assign samples.ready = !valid1;
  assign accept        = samples.valid && samples.ready;
  assign sample        = SAMPLE_BITS'(samples.light_sample);

  genvar i;
  generate
    for (i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
        ltds_cell u_cell (.clk(clk), .shift(accept), .d(sample), .q(taps[i]));
      end else begin : g_link
        ltds_cell u_cell (.clk(clk), .shift(accept), .d(taps[i-1]), .q(taps[i]));
      end
    end
  endgenerate

  assign full            = (fill_count == FILL_BITS'(WINDOW - 1));
  assign dropped         = wrapped ? taps[WINDOW-1] : '0;
  assign window_sum_next = window_sum + SUM_BITS'(sample) - SUM_BITS'(dropped);
  assign avg_prod        = PROD_BITS'(window_sum_next) * PROD_BITS'(AVG_RECIP);
  assign avg             = SAMPLE_BITS'(avg_prod >> DIV_SHIFT);
  assign tick_count_next = tick_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      wrapped    <= 1'b0;
      window_sum <= '0;
      tick_count <= '0;
    end else if (accept) begin
      window_sum <= window_sum_next;
      tick_count <= tick_count_next;
      if (full) begin
        wrapped <= 1'b1;
      end else begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  ltds_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (accept && full),
    .avg    (avg),
    .cfg    (cfg),
    .status (status)
  );

  assign word_new.output_on      = status.output_on;
  assign word_new.switch_event   = status.switch_event;
  assign word_new.tick_stamp     = tick_count_next;
  assign word_new.window_average = full ? LIGHT_BITS'(avg) : '0;
  assign word_new.average_valid  = full;

  assign pop = valid0 && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else if (pop) begin
      if (valid1) begin
        valid1 <= accept;
      end else begin
        valid0 <= accept;
      end
    end else if (accept) begin
      if (!valid0) begin
        valid0 <= 1'b1;
      end else begin
        valid1 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (valid1) begin
        word0 <= word1;
        if (accept) begin
          word1 <= word_new;
        end
      end else if (accept) begin
        word0 <= word_new;
      end
    end else if (accept) begin
      if (!valid0) begin
        word0 <= word_new;
      end else begin
        word1 <= word_new;
      end
    end
  end

  assign results.valid          = valid0;
  assign results.output_on      = word0.output_on;
  assign results.switch_event   = word0.switch_event;
  assign results.tick_stamp     = word0.tick_stamp;
  assign results.window_average = word0.window_average;
  assign results.average_valid  = word0.average_valid;
endmodule
